// ----- design/rvx_pkg.sv -----
package rvx_pkg;

  localparam int unsigned MEM_BYTES_DEF   = 32'd16777216;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] PC_RESET = 32'h0000_1000;

  localparam logic [6:0] OPC_LUI   = 7'h37;
  localparam logic [6:0] OPC_AUIPC = 7'h17;
  localparam logic [6:0] OPC_OPIMM = 7'h13;
  localparam logic [6:0] OPC_OP    = 7'h33;

  localparam logic [1:0] LEN_WIDE = 2'b11;

  typedef enum logic [2:0] {
    ST_EXEC        = 3'd0,
    ST_UNKNOWN     = 3'd1,
    ST_COMPRESSED  = 3'd2,
    ST_FETCH_RANGE = 3'd3,
    ST_HALTED      = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] instr;
    logic [31:0] addr;
  } item_t;

endpackage

// ----- design/rv32i_alu_subset_executor_top.sv -----
// An accepted item goes through the queue, the execute register and the output register.
// Throughput: one item per cycle unless output stalls (one register-file read stage).
// A 4-entry queue between decode and execute lets input keep flowing while output stalls.
// Reset (rst_ni low, async): pc = 0x1000, not halted, register file reads zero, queue empty.
// A start_pc write loads the pc and takes effect on the next accepted item.
module rv32i_alu_subset_executor_top #(
  parameter int unsigned MEM_BYTES   = rvx_pkg::MEM_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH = rvx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i,      // start_pc
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] instruction
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] status, [3] wrote_register, [8:4] dest_register,
  // [40:9] written_value, [72:41] instruction_address, [79:73] zero
  output logic [79:0] m_axis_tdata_o
);

  rvx_pkg::item_t push_item, head_item;
  logic           push, q_full, q_valid, pop;

  rvx_front #(
    .MEM_BYTES (MEM_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .s_valid_i   (s_axis_tvalid_i),
    .s_instr_i   (s_axis_tdata_i),
    .s_ready_o   (s_axis_tready_o),
    .q_full_i    (q_full),
    .q_push_o    (push),
    .q_item_o    (push_item)
  );

  rvx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_item)
  );

  rvx_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (head_item),
    .q_pop_o   (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_data_o  (m_axis_tdata_o),
    .m_ready_i (m_axis_tready_i)
  );

endmodule

// ----- design/rvx_front.sv -----
module rvx_front #(
  parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [23:0]         cfg_data_i,
  output logic                cfg_ready_o,
  input  logic                s_valid_i,
  input  logic [31:0]         s_instr_i,
  output logic                s_ready_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output rvx_pkg::item_t      q_item_o
);

  logic [31:0]      pc_q, pc_d;
  logic             halted_q, halted_d;
  logic             wide;
  logic [32:0]      end_addr;
  logic             out_range;
  logic             accept;
  rvx_pkg::status_e status;

  assign cfg_ready_o = 1'b1;
  assign s_ready_o   = !q_full_i;
  assign accept      = s_valid_i && !q_full_i;
  assign q_push_o    = accept;

  assign wide      = (s_instr_i[1:0] == rvx_pkg::LEN_WIDE);
  // fetch must fit entirely below the end of memory
  assign end_addr  = {1'b0, pc_q} + (wide ? 33'd4 : 33'd2);
  assign out_range = (end_addr > 33'(MEM_BYTES));

  always_comb begin
    if (halted_q) begin
      status = rvx_pkg::ST_HALTED;
    end else if (out_range) begin
      status = rvx_pkg::ST_FETCH_RANGE;
    end else if (!wide) begin
      status = rvx_pkg::ST_COMPRESSED;
    end else if (s_instr_i[6:0] inside {rvx_pkg::OPC_LUI, rvx_pkg::OPC_AUIPC,
                                         rvx_pkg::OPC_OPIMM, rvx_pkg::OPC_OP}) begin
      status = rvx_pkg::ST_EXEC;
    end else begin
      status = rvx_pkg::ST_UNKNOWN;
    end
  end

  assign q_item_o.status = status;
  assign q_item_o.instr  = s_instr_i;
  assign q_item_o.addr   = pc_q;

  always_comb begin
    pc_d     = pc_q;
    halted_d = halted_q;
    if (cfg_valid_i) begin
      pc_d = {8'b0, cfg_data_i};
    end else if (accept) begin
      if (status == rvx_pkg::ST_EXEC) begin
        pc_d = pc_q + 32'd4;
      end else if (status != rvx_pkg::ST_HALTED) begin
        halted_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= rvx_pkg::PC_RESET;
      halted_q <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ----- design/rvx_queue.sv -----
module rvx_queue #(
  parameter int unsigned DEPTH = rvx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rvx_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rvx_pkg::item_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rvx_pkg::item_t      slots_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- design/rvx_back.sv -----
module rvx_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  rvx_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           m_valid_o,
  output logic [79:0]    m_data_o,
  input  logic           m_ready_i
);

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;

  // register file: memory with registered reads, valid bits model the reset clear
  logic [31:0]    rf_mem [32];
  logic [31:0]    rf_valid_q;

  logic           rd_issue;
  logic [4:0]     rs1, rs2;

  rvx_pkg::item_t ex_item_q;
  logic           ex_valid_q;
  logic [31:0]    rdata1_q, rdata2_q;
  logic           fwd1_q, fwd2_q, zero1_q, zero2_q;
  logic [31:0]    fwd_val_q;

  logic           out_valid_q;
  logic [79:0]    out_data_q;
  logic           out_free, ex_adv;

  logic [31:0]    op_a, reg_b, op_b, alu_val, val;
  logic [2:0]     f3;
  logic           alt, sub_ok, is_exec;
  logic [4:0]     rd;
  logic [6:0]     opc;

  logic           wr_en;
  logic [4:0]     wr_addr;
  logic [31:0]    wr_data;

  logic           res_wrote;
  logic [4:0]     res_rd;
  logic [31:0]    res_val;

  assign out_free = !out_valid_q || m_ready_i;
  assign ex_adv   = ex_valid_q && out_free;
  assign rd_issue = q_valid_i && (!ex_valid_q || ex_adv);
  assign q_pop_o  = rd_issue;

  assign rs1 = q_item_i.instr[19:15];
  assign rs2 = q_item_i.instr[24:20];

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rdata1_q <= rf_mem[rs1];
      rdata2_q <= rf_mem[rs2];
    end
    if (wr_en) begin
      rf_mem[wr_addr] <= wr_data;
    end
  end

  // a write landing at the read edge is bypassed
  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      ex_item_q <= q_item_i;
      fwd1_q    <= wr_en && (wr_addr == rs1);
      fwd2_q    <= wr_en && (wr_addr == rs2);
      zero1_q   <= !rf_valid_q[rs1];
      zero2_q   <= !rf_valid_q[rs2];
      fwd_val_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
    end else if (wr_en) begin
      rf_valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (rd_issue) begin
      ex_valid_q <= 1'b1;
    end else if (ex_adv) begin
      ex_valid_q <= 1'b0;
    end
  end

  assign op_a  = fwd1_q ? fwd_val_q : (zero1_q ? 32'd0 : rdata1_q);
  assign reg_b = fwd2_q ? fwd_val_q : (zero2_q ? 32'd0 : rdata2_q);

  assign opc     = ex_item_q.instr[6:0];
  assign f3      = ex_item_q.instr[14:12];
  assign alt     = ex_item_q.instr[30];
  assign rd      = ex_item_q.instr[11:7];
  assign is_exec = (ex_item_q.status == rvx_pkg::ST_EXEC);
  assign sub_ok  = (opc == rvx_pkg::OPC_OP);

  always_comb begin
    if (opc == rvx_pkg::OPC_OP) begin
      op_b = reg_b;
    end else if (f3 inside {F3_SLL, F3_SR}) begin
      op_b = {27'b0, ex_item_q.instr[24:20]};
    end else begin
      op_b = {{20{ex_item_q.instr[31]}}, ex_item_q.instr[31:20]};
    end
  end

  always_comb begin
    case (f3)
      F3_ADD:  alu_val = (sub_ok && alt) ? op_a - op_b : op_a + op_b;
      F3_SLL:  alu_val = op_a << op_b[4:0];
      F3_SLT:  alu_val = {31'b0, $signed(op_a) < $signed(op_b)};
      F3_SLTU: alu_val = {31'b0, op_a < op_b};
      F3_XOR:  alu_val = op_a ^ op_b;
      F3_SR:   alu_val = alt ? 32'($signed(op_a) >>> op_b[4:0]) : op_a >> op_b[4:0];
      F3_OR:   alu_val = op_a | op_b;
      default: alu_val = op_a & op_b;
    endcase
  end

  always_comb begin
    case (opc)
      rvx_pkg::OPC_LUI:   val = {ex_item_q.instr[31:12], 12'b0};
      rvx_pkg::OPC_AUIPC: val = {ex_item_q.instr[31:12], 12'b0} + ex_item_q.addr;
      rvx_pkg::OPC_OPIMM: val = alu_val;
      rvx_pkg::OPC_OP:    val = alu_val;
      default:            val = 32'd0;
    endcase
  end

  assign res_wrote = is_exec && (rd != 5'd0);
  assign res_rd    = is_exec ? rd : 5'd0;
  assign res_val   = res_wrote ? val : 32'd0;

  assign wr_en   = ex_adv && res_wrote;
  assign wr_addr = rd;
  assign wr_data = val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= ex_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_adv) begin
      out_data_q <= {7'b0, ex_item_q.addr, res_val, res_rd, res_wrote, ex_item_q.status};
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> wr_addr != 5'd0)
    else $error("write to x0");

  a_x0_never_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rf_valid_q[0])
    else $error("x0 marked written");

  a_wrote_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[3] |-> out_data_q[2:0] == rvx_pkg::ST_EXEC)
    else $error("register write reported on non-executed item");

  a_ex_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_valid_q && !out_free |=> ex_valid_q && $stable(ex_item_q))
    else $error("execute stage lost a stalled item");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

endmodule
